// File: hw/rtl/lmbc_pkg.sv
// Package with the mode codes, register indexes, reset values and color blend for the LED driver.
package lmbc_pkg;

  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int BLINK_W    = 16;
  localparam int FADE_W     = 8;
  localparam int MODE_W     = 3;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_OFF    = 3'd0;
  localparam mode_t MODE_STEADY = 3'd1;
  localparam mode_t MODE_SLOW   = 3'd2;
  localparam mode_t MODE_FAST   = 3'd3;
  localparam mode_t MODE_FADE   = 3'd4;
  localparam mode_t MODE_HOLD   = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE          = 3'd0,
    CFG_BASE_COLOR    = 3'd1,
    CFG_SLOW_INTERVAL = 3'd2,
    CFG_FAST_INTERVAL = 3'd3,
    CFG_FADE_PERIOD   = 3'd4
  } cfg_idx_t;

  localparam logic [COLOR_W-1:0] BASE_COLOR_RST    = 24'hFF0000;
  localparam logic [BLINK_W-1:0] SLOW_INTERVAL_RST = 16'd1000;
  localparam logic [BLINK_W-1:0] FAST_INTERVAL_RST = 16'd500;
  localparam logic [FADE_W-1:0]  FADE_PERIOD_RST   = 8'd10;

  // Blend of one channel with its inverse, divided by 255 exactly for 16-bit sums.
  function automatic logic [7:0] blend_chan(input logic [7:0] c, input logic [7:0] w);
    logic [16:0] acc;
    logic [16:0] adj;
    acc = 17'(16'(c) * 16'(8'hFF - w)) + 17'(16'(8'hFF - c) * 16'(w));
    adj = acc + 17'(acc[16:8]) + 17'd1;
    return adj[15:8];
  endfunction

  function automatic logic [COLOR_W-1:0] blend_color(input logic [COLOR_W-1:0] col,
                                                     input logic [7:0] w);
    logic [COLOR_W-1:0] res;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      res[i*8 +: 8] = blend_chan(col[i*8 +: 8], w);
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/led_mode_blink_crossfade.sv
// RGB LED mode driver: off, steady, slow and fast blink, crossfade and hold.
// A request accepted into the input register moves on to the result register and out_valid once that register is free.
// Throughput: one request per cycle through an input register and a result register, unless out_ready stalls them.
// Reset (synchronous, rst_n low) clears the valid flags of both stages, the counters and the LED color,
// and loads the register defaults.
module led_mode_blink_crossfade
  import lmbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_tick,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COLOR_W-1:0]    out_pixel_color,
  output logic                  out_refreshed,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  mode_t              mode_r;
  logic [COLOR_W-1:0] base_color_r;
  logic [BLINK_W-1:0] slow_interval_r;
  logic [BLINK_W-1:0] fast_interval_r;
  logic [FADE_W-1:0]  fade_period_r;

  logic [COLOR_W-1:0] led_color_r, led_color_nxt;
  logic [BLINK_W-1:0] blink_elapsed_r, blink_elapsed_nxt;
  logic [FADE_W-1:0]  fade_elapsed_r, fade_elapsed_nxt;
  logic [FADE_W-1:0]  fade_weight_r, fade_weight_nxt;

  logic               s1_vld_r;
  logic               s1_tick_r;
  logic               out_vld_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_refr_r;
  logic               refreshed_nxt;

  logic               advance;
  logic               step;
  logic [BLINK_W-1:0] blink_inc;
  logic [FADE_W-1:0]  fade_inc;
  logic [BLINK_W-1:0] interval;

  assign advance  = !out_vld_r || out_ready;
  assign step     = s1_vld_r && advance;
  assign in_ready = !s1_vld_r || advance;

  assign out_valid       = out_vld_r;
  assign out_pixel_color = out_color_r;
  assign out_refreshed   = out_refr_r;

  always_comb begin
    blink_inc = blink_elapsed_r;
    fade_inc  = fade_elapsed_r;
    if (s1_tick_r) begin
      if (blink_elapsed_r != '1) blink_inc = blink_elapsed_r + 1'b1;
      if (fade_elapsed_r != '1) fade_inc = fade_elapsed_r + 1'b1;
    end
    interval          = (mode_r == MODE_SLOW) ? slow_interval_r : fast_interval_r;
    led_color_nxt     = led_color_r;
    blink_elapsed_nxt = blink_inc;
    fade_elapsed_nxt  = fade_inc;
    fade_weight_nxt   = fade_weight_r;
    refreshed_nxt     = 1'b1;
    case (mode_r)
      MODE_SLOW, MODE_FAST: begin
        if (blink_inc >= interval) begin
          blink_elapsed_nxt = '0;
          led_color_nxt     = (led_color_r == base_color_r) ? '0 : base_color_r;
        end else begin
          refreshed_nxt = 1'b0;
        end
      end
      MODE_OFF:    led_color_nxt = '0;
      MODE_STEADY: led_color_nxt = base_color_r;
      MODE_FADE: begin
        if (fade_inc >= fade_period_r) begin
          fade_elapsed_nxt = '0;
          led_color_nxt    = blend_color(base_color_r, fade_weight_r);
          fade_weight_nxt  = fade_weight_r + 1'b1;
        end
      end
      MODE_HOLD: led_color_nxt = led_color_r;
      default:   led_color_nxt = led_color_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_OFF;
      base_color_r    <= BASE_COLOR_RST;
      slow_interval_r <= SLOW_INTERVAL_RST;
      fast_interval_r <= FAST_INTERVAL_RST;
      fade_period_r   <= FADE_PERIOD_RST;
      led_color_r     <= '0;
      blink_elapsed_r <= '0;
      fade_elapsed_r  <= '0;
      fade_weight_r   <= '0;
      s1_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= s1_vld_r;
      end
      if (step) begin
        led_color_r     <= led_color_nxt;
        blink_elapsed_r <= blink_elapsed_nxt;
        fade_elapsed_r  <= fade_elapsed_nxt;
        fade_weight_r   <= fade_weight_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: begin
            if (cfg_wdata[MODE_W-1:0] != mode_r) begin
              mode_r          <= cfg_wdata[MODE_W-1:0];
              blink_elapsed_r <= '0;
            end
          end
          CFG_BASE_COLOR:    base_color_r    <= cfg_wdata[COLOR_W-1:0];
          CFG_SLOW_INTERVAL: slow_interval_r <= cfg_wdata[BLINK_W-1:0];
          CFG_FAST_INTERVAL: fast_interval_r <= cfg_wdata[BLINK_W-1:0];
          CFG_FADE_PERIOD:   fade_period_r   <= cfg_wdata[FADE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_tick_r <= in_tick;
    end
    if (step) begin
      out_color_r <= led_color_nxt;
      out_refr_r  <= refreshed_nxt;
    end
  end

endmodule

// File: hw/rtl/lmbc_checker.sv
// Port-level checker for the LED mode driver and its bind statement.
module lmbc_checker
  import lmbc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COLOR_W-1:0]    out_pixel_color,
  input logic                  out_refreshed
);

  logic [COLOR_W-1:0] last_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_color_r <= '0;
    end else if (out_valid && out_ready) begin
      last_color_r <= out_pixel_color;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result present right after reset.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled while no result is pending.");

  a_no_refresh_same_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_refreshed) |-> (out_pixel_color == last_color_r))
    else $error("Color changed on a request without a refresh.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pixel_color)
                                   && $stable(out_refreshed)))
    else $error("Stalled result changed.");

endmodule

bind led_mode_blink_crossfade lmbc_checker u_lmbc_checker (.*);
